FILE: hdl/mts_pkg.sv
// Shared types, codes and helpers of the multi-timeout scheduler.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int SLOT_BITS     = 4;
    localparam int SLEEP_CAP     = 60000000;
    localparam logic [31:0] MAX_TIMEOUT_RST = 32'd60000000;

    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_ONESHOT  = 2'd1;
    localparam logic [1:0] KIND_PERIODIC = 2'd2;
    localparam logic [1:0] KIND_DISCARD  = 2'd3;

    localparam logic RES_FIRE  = 1'b0;
    localparam logic RES_SLEEP = 1'b1;

    localparam logic CFG_MIN_PERIOD  = 1'b0;
    localparam logic CFG_MAX_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [31:0] duration;
        logic [31:0] now_us;
    } cmd_t;

    typedef struct packed {
        logic        result_kind;
        logic [3:0]  fired_slot;
        logic [31:0] fire_count;
        logic [25:0] sleep_us;
        logic        last;
    } res_t;

    typedef enum logic [1:0] {
        CELL_NOP,
        CELL_REMOVE,
        CELL_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t        op;
        logic [3:0]      key;
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TIME,
        ST_HEAD,
        ST_POP,
        ST_FIRE1,
        ST_DIV,
        ST_ADV1,
        ST_ADV2,
        ST_REINS,
        ST_POST,
        ST_ARM_RM,
        ST_ARM_INS,
        ST_ARM_CHK,
        ST_SLEEP1,
        ST_SLEEP2,
        ST_FLUSH
    } state_t;

    // Deadline (dl, dw) is due at time (t, tw); the wrap bits decide the order.
    function automatic logic due_at(logic [63:0] dl, logic dw, logic [63:0] t, logic tw);
        return (tw == dw) ? (t >= dl) : (t < dl);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/mts_cell.sv
// One queue cell: holds a pending slot and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module mts_cell #(
    parameter int TIME_BITS = mts_pkg::TIME_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mts_pkg::cell_ctrl_t      ctrl,
    input  wire logic                     head,
    input  wire logic [2*TIME_BITS+5:0]   ins,
    input  wire logic [2*TIME_BITS+5:0]   left,
    input  wire logic [2*TIME_BITS+5:0]   right,
    input  wire logic                     kill_in,
    input  wire logic                     hit_in,
    output logic      [2*TIME_BITS+5:0]   q,
    output logic                          kill_out,
    output logic                          hit_out
);

    localparam int TW = TIME_BITS;
    localparam int EW = 2 * TW + 6;

    logic              valid_reg, valid_next;
    logic [EW-2:0]     data_reg, data_next;
    logic [TW-1:0]     dl, ins_dl;
    logic              w, ins_w;
    logic [3:0]        slot;
    logic              match, ins_first;

    assign dl     = data_reg[TW-1:0];
    assign w      = data_reg[2*TW];
    assign slot   = data_reg[2*TW+4:2*TW+1];
    assign ins_dl = ins[TW-1:0];
    assign ins_w  = ins[2*TW];

    assign match    = valid_reg && (slot == ctrl.key);
    assign kill_out = kill_in | match;

    // The head cell lets a tie go in front; deeper cells keep equal deadlines ahead.
    always_comb
    begin
        if (head)
            ins_first = mts_pkg::due_at(64'(ins_dl), ins_w, 64'(dl), w);
        else
            ins_first = !mts_pkg::due_at(64'(dl), w, 64'(ins_dl), ins_w);
    end

    assign hit_out = hit_in | !valid_reg | ins_first;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        unique case (ctrl.op)
            mts_pkg::CELL_NOP:
            begin
            end
            mts_pkg::CELL_REMOVE:
            begin
                if (kill_out)
                begin
                    valid_next = right[EW-1];
                    data_next  = right[EW-2:0];
                end
            end
            mts_pkg::CELL_INSERT:
            begin
                if (hit_in)
                begin
                    valid_next = left[EW-1];
                    data_next  = left[EW-2:0];
                end
                else if (hit_out)
                begin
                    valid_next = ins[EW-1];
                    data_next  = ins[EW-2:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = {valid_reg, data_reg};

endmodule

`default_nettype wire

FILE: hdl/mts_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module mts_div #(
    parameter int TIME_BITS = mts_pkg::TIME_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [TIME_BITS-1:0] dividend,
    input  wire logic [TIME_BITS-1:0] divisor,
    output logic                      done,
    output logic      [TIME_BITS-1:0] quo,
    output logic      [TIME_BITS-1:0] rem
);

    localparam int TW = TIME_BITS;
    localparam int CW = $clog2(TW + 1);

    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [TW-1:0] rem_reg, quo_reg, dsr_reg;
    logic [TW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, quo_reg[TW-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(TW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? TW'(trial - {1'b0, dsr_reg}) : TW'(trial);
            quo_reg <= {quo_reg[TW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

FILE: hdl/multi_timeout_scheduler_top.sv
// Top level of the multi-timeout scheduler: sequencer over a sorted chain of queue cells.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------
//   cmd     | cmd_valid/cmd_ready | kind, slot, duration, now_us
//   res     | res_valid/res_ready | result_kind, fired_slot, fire_count,
//           |                     | sleep_us, last
//   cfg     | cfg_we              | cfg_index, cfg_data
//
// One item at a time: a new command is taken only in the idle state, once the
// last one is through. A periodic slot's fire count is set by the bit-serial
// catch-up divider. Queue insert and remove act on the whole cell chain in
// parallel. Reset empties the queue at once. Results pass through a one-beat
// pending stage and an output register; a stalled res_ready holds the
// sequencer at its next beat.
`timescale 1ns / 1ps
`default_nettype none

module multi_timeout_scheduler_top #(
    parameter int NUM_SLOTS = mts_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS = mts_pkg::TIME_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire mts_pkg::cmd_t cmd,
    output logic               res_valid,
    input  wire logic          res_ready,
    output mts_pkg::res_t      res,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [31:0]   cfg_data
);

    localparam int TW = TIME_BITS;
    localparam int EW = 2 * TW + 6;
    localparam int IW = $clog2(NUM_SLOTS + 1);
    localparam int VW = (TW > 32) ? TW : 32;
    localparam int QW = (TW > 32) ? TW : 32;

    mts_pkg::state_t state_reg, state_next;

    mts_pkg::cmd_t   cmd_reg;
    logic [TW-1:0]   cur_time_reg;
    logic            cur_wrap_reg;
    logic [TW-1:0]   hd_reg;
    logic            hdw_reg;
    logic [31:0]     min_period_reg;
    logic [31:0]     max_to_reg;
    logic [IW-1:0]   iter_reg;

    logic [3:0]      w_slot_reg;
    logic [TW-1:0]   w_dl_reg, w_per_reg;
    logic            w_w_reg;

    logic            sl_empty_reg;
    logic [TW-1:0]   wk_reg;
    logic            ww_reg;

    mts_pkg::res_t   pend_reg;
    logic            pend_valid_reg;
    mts_pkg::res_t   out_reg;
    logic            out_valid_reg;

    // cell chain
    mts_pkg::cell_ctrl_t ctrl;
    logic [EW-1:0]       cell_q [NUM_SLOTS];
    logic [NUM_SLOTS:0]  kill_c, hit_c;
    logic [EW-1:0]       ins_entry;

    logic            c0_valid, c0_w;
    logic [3:0]      c0_slot;
    logic [TW-1:0]   c0_dl, c0_per;

    assign c0_dl    = cell_q[0][TW-1:0];
    assign c0_per   = cell_q[0][2*TW-1:TW];
    assign c0_w     = cell_q[0][2*TW];
    assign c0_slot  = cell_q[0][2*TW+4:2*TW+1];
    assign c0_valid = cell_q[0][EW-1];

    assign ins_entry = {1'b1, w_slot_reg, w_w_reg, w_per_reg, w_dl_reg};
    assign kill_c[0] = 1'b0;
    assign hit_c[0]  = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOTS; gi++)
        begin : g_cell
            logic [EW-1:0] left_e, right_e;
            if (gi == 0)
            begin : g_first
                assign left_e = '0;
            end
            else
            begin : g_mid
                assign left_e = cell_q[gi-1];
            end
            if (gi == NUM_SLOTS - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = cell_q[gi+1];
            end
            mts_cell #(
                .TIME_BITS(TIME_BITS)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .head     (gi == 0),
                .ins      (ins_entry),
                .left     (left_e),
                .right    (right_e),
                .kill_in  (kill_c[gi]),
                .hit_in   (hit_c[gi]),
                .q        (cell_q[gi]),
                .kill_out (kill_c[gi+1]),
                .hit_out  (hit_c[gi+1])
            );
        end
    endgenerate

    // catch-up divider
    logic          div_start, div_done;
    logic [TW-1:0] div_quo, div_rem;

    mts_div #(
        .TIME_BITS(TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (TW'(cur_time_reg - c0_dl)),
        .divisor  (c0_per),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // shared datapath terms
    logic            cmd_fire, out_of_range;
    logic [TW-1:0]   now_t, hd_new, dur_t, arm_dl;
    logic            wrap_n, hd_due, head_due, head_is_w;
    logic [QW-1:0]   q_ext;
    logic [31:0]     fire_cnt;
    logic [TW-1:0]   d1, d2;
    logic [VW-1:0]   v_raw, v_clamp;

    assign cmd_fire     = cmd_valid && cmd_ready;
    assign out_of_range = (cmd.kind != mts_pkg::KIND_TICK) &&
                          (32'(cmd.slot) >= 32'(NUM_SLOTS));
    assign now_t    = TW'(cmd_reg.now_us);
    assign wrap_n   = (cur_time_reg > now_t) ? !cur_wrap_reg : cur_wrap_reg;
    assign hd_new   = TW'(now_t + TW'(min_period_reg));
    assign hd_due   = mts_pkg::due_at(64'(hd_reg), hdw_reg, 64'(now_t), wrap_n);
    assign head_due = c0_valid &&
                      mts_pkg::due_at(64'(c0_dl), c0_w, 64'(cur_time_reg), cur_wrap_reg);
    assign head_is_w = c0_valid && (c0_slot == w_slot_reg);
    assign dur_t    = TW'(cmd_reg.duration);
    assign arm_dl   = (cmd_reg.kind == mts_pkg::KIND_ONESHOT) ?
                      TW'(cur_time_reg + dur_t) : cur_time_reg;

    assign q_ext    = QW'(div_quo);
    assign fire_cnt = (q_ext >= QW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(q_ext + QW'(1));
    assign d1       = TW'(cur_time_reg - div_rem);
    assign d2       = TW'(w_dl_reg + w_per_reg);

    always_comb
    begin
        if (sl_empty_reg)
            v_raw = VW'(max_to_reg);
        else if (mts_pkg::due_at(64'(wk_reg), ww_reg, 64'(cur_time_reg), cur_wrap_reg))
            v_raw = '0;
        else
            v_raw = VW'(TW'(wk_reg - cur_time_reg));
        if (v_raw > VW'(mts_pkg::SLEEP_CAP))
            v_clamp = VW'(mts_pkg::SLEEP_CAP);
        else if (v_raw == '0)
            v_clamp = VW'(1);
        else
            v_clamp = v_raw;
    end

    // result staging
    logic            out_free, emit_ok, emit_req, emit_fire, flush_fire;
    mts_pkg::res_t   emit_data;
    mts_pkg::res_t   pend_tagged;

    assign out_free   = !out_valid_reg || res_ready;
    assign emit_ok    = !pend_valid_reg || out_free;
    assign emit_fire  = emit_req && emit_ok;
    assign flush_fire = (state_reg == mts_pkg::ST_FLUSH) && pend_valid_reg && out_free;

    // mark the pending beat as final when it leaves during flush
    always_comb
    begin
        pend_tagged      = pend_reg;
        pend_tagged.last = flush_fire;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mts_pkg::ST_IDLE:
            begin
                if (cmd_fire && !out_of_range && (cmd.kind != mts_pkg::KIND_DISCARD))
                    state_next = mts_pkg::ST_TIME;
            end
            mts_pkg::ST_TIME:
                state_next = hd_due ? mts_pkg::ST_HEAD : mts_pkg::ST_POST;
            mts_pkg::ST_HEAD:
            begin
                if ((iter_reg == IW'(NUM_SLOTS)) || !head_due)
                    state_next = mts_pkg::ST_POST;
                else
                    state_next = mts_pkg::ST_POP;
            end
            mts_pkg::ST_POP:
                state_next = (c0_per == '0) ? mts_pkg::ST_FIRE1 : mts_pkg::ST_DIV;
            mts_pkg::ST_FIRE1:
            begin
                if (emit_ok)
                    state_next = mts_pkg::ST_HEAD;
            end
            mts_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = mts_pkg::ST_ADV1;
            end
            mts_pkg::ST_ADV1:
            begin
                if (emit_ok)
                    state_next = mts_pkg::ST_ADV2;
            end
            mts_pkg::ST_ADV2:
                state_next = mts_pkg::ST_REINS;
            mts_pkg::ST_REINS:
                state_next = mts_pkg::ST_HEAD;
            mts_pkg::ST_POST:
            begin
                priority if (cmd_reg.kind == mts_pkg::KIND_TICK)
                    state_next = mts_pkg::ST_SLEEP1;
                else if ((cmd_reg.kind == mts_pkg::KIND_PERIODIC) && (dur_t == '0))
                    state_next = mts_pkg::ST_FLUSH;
                else
                    state_next = mts_pkg::ST_ARM_RM;
            end
            mts_pkg::ST_ARM_RM:
                state_next = mts_pkg::ST_ARM_INS;
            mts_pkg::ST_ARM_INS:
                state_next = mts_pkg::ST_ARM_CHK;
            mts_pkg::ST_ARM_CHK:
            begin
                if (!head_is_w || emit_ok)
                    state_next = mts_pkg::ST_FLUSH;
            end
            mts_pkg::ST_SLEEP1:
                state_next = mts_pkg::ST_SLEEP2;
            mts_pkg::ST_SLEEP2:
            begin
                if (emit_ok)
                    state_next = mts_pkg::ST_FLUSH;
            end
            mts_pkg::ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = mts_pkg::ST_IDLE;
            end
            default:
                state_next = mts_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        cmd_ready = 1'b0;
        ctrl      = '{op: mts_pkg::CELL_NOP, key: '0};
        div_start = 1'b0;
        emit_req  = 1'b0;
        emit_data = '{result_kind: mts_pkg::RES_FIRE, fired_slot: w_slot_reg,
                      fire_count: 32'd1, sleep_us: '0, last: 1'b0};
        unique case (state_reg)
            mts_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_fire && !out_of_range && (cmd.kind == mts_pkg::KIND_DISCARD))
                    ctrl = '{op: mts_pkg::CELL_REMOVE, key: cmd.slot};
            end
            mts_pkg::ST_POP:
            begin
                ctrl      = '{op: mts_pkg::CELL_REMOVE, key: c0_slot};
                div_start = (c0_per != '0);
            end
            mts_pkg::ST_FIRE1:
                emit_req = 1'b1;
            mts_pkg::ST_ADV1:
            begin
                emit_req             = 1'b1;
                emit_data.fire_count = fire_cnt;
            end
            mts_pkg::ST_REINS, mts_pkg::ST_ARM_INS:
                ctrl = '{op: mts_pkg::CELL_INSERT, key: w_slot_reg};
            mts_pkg::ST_POST:
            begin
                if ((cmd_reg.kind == mts_pkg::KIND_PERIODIC) && (dur_t == '0))
                    ctrl = '{op: mts_pkg::CELL_REMOVE, key: cmd_reg.slot};
            end
            mts_pkg::ST_ARM_RM:
                ctrl = '{op: mts_pkg::CELL_REMOVE, key: w_slot_reg};
            mts_pkg::ST_ARM_CHK:
            begin
                emit_req  = head_is_w;
                emit_data = '{result_kind: mts_pkg::RES_SLEEP, fired_slot: '0,
                              fire_count: '0, sleep_us: '0, last: 1'b0};
            end
            mts_pkg::ST_SLEEP2:
            begin
                emit_req  = 1'b1;
                emit_data = '{result_kind: mts_pkg::RES_SLEEP, fired_slot: '0,
                              fire_count: '0, sleep_us: 26'(v_clamp), last: 1'b0};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mts_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // time, handling deadline, configuration, pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_time_reg   <= '0;
            cur_wrap_reg   <= 1'b0;
            hd_reg         <= '0;
            hdw_reg        <= 1'b0;
            min_period_reg <= '0;
            max_to_reg     <= mts_pkg::MAX_TIMEOUT_RST;
            iter_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mts_pkg::CFG_MIN_PERIOD:  min_period_reg <= cfg_data;
                    mts_pkg::CFG_MAX_TIMEOUT: max_to_reg     <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == mts_pkg::ST_TIME)
            begin
                cur_time_reg <= now_t;
                cur_wrap_reg <= wrap_n;
                iter_reg     <= '0;
                if (hd_due)
                begin
                    hd_reg  <= hd_new;
                    hdw_reg <= (now_t > hd_new) ? !wrap_n : wrap_n;
                end
            end
            if (state_reg == mts_pkg::ST_POP)
                iter_reg <= iter_reg + IW'(1);
        end
    end

    // work registers of the slot in hand
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
            cmd_reg <= cmd;
        unique case (state_reg)
            mts_pkg::ST_POP:
            begin
                w_slot_reg <= c0_slot;
                w_dl_reg   <= c0_dl;
                w_w_reg    <= c0_w;
                w_per_reg  <= c0_per;
            end
            mts_pkg::ST_ADV1:
            begin
                if (emit_ok)
                begin
                    w_dl_reg <= d1;
                    w_w_reg  <= (d1 < w_dl_reg) ? !w_w_reg : w_w_reg;
                end
            end
            mts_pkg::ST_ADV2:
            begin
                w_dl_reg <= d2;
                w_w_reg  <= (d2 < w_dl_reg) ? !w_w_reg : w_w_reg;
            end
            mts_pkg::ST_POST:
            begin
                w_slot_reg <= cmd_reg.slot;
                w_dl_reg   <= arm_dl;
                w_w_reg    <= (cur_time_reg > arm_dl) ? !cur_wrap_reg : cur_wrap_reg;
                w_per_reg  <= (cmd_reg.kind == mts_pkg::KIND_ONESHOT) ? '0 : dur_t;
            end
            mts_pkg::ST_SLEEP1:
            begin
                sl_empty_reg <= !c0_valid;
                if (mts_pkg::due_at(64'(c0_dl), c0_w, 64'(hd_reg), hdw_reg))
                begin
                    wk_reg <= hd_reg;
                    ww_reg <= hdw_reg;
                end
                else
                begin
                    wk_reg <= c0_dl;
                    ww_reg <= c0_w;
                end
            end
            default:
            begin
            end
        endcase
    end

    // hold one beat back so the final one can carry last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (emit_fire)
                pend_valid_reg <= 1'b1;
            else if (flush_fire)
                pend_valid_reg <= 1'b0;
            if ((emit_fire && pend_valid_reg) || flush_fire)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
            pend_reg <= emit_data;
        if ((emit_fire && pend_valid_reg) || flush_fire)
            out_reg <= pend_tagged;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

FILE: hdl/mts_checker.sv
// Port-level checks of the scheduler and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mts_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          res_valid,
    input wire logic          res_ready,
    input wire mts_pkg::res_t res
);

    // a stalled beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result beat changed while stalled");

    a_fire_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.result_kind == mts_pkg::RES_FIRE) |->
            (res.sleep_us == '0) && (res.fire_count != '0))
        else $error("fire beat with bad fields");

    a_sleep_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.result_kind == mts_pkg::RES_SLEEP) |->
            (res.fire_count == '0) && (res.fired_slot == '0))
        else $error("sleep beat with bad fields");

    a_sleep_cap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.sleep_us <= 26'(mts_pkg::SLEEP_CAP)))
        else $error("sleep request above cap");

    // a tick's sleep request always closes its beats
    a_sleep_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.result_kind == mts_pkg::RES_SLEEP) && (res.sleep_us != '0)
            |-> res.last)
        else $error("sleep request not marked last");

endmodule

bind multi_timeout_scheduler_top mts_checker u_mts_checker (.*);

`default_nettype wire
